// File: rtl/core/skvt_pkg.sv
`default_nettype none
package skvt_pkg;
   localparam int TableDepth = 64;
   localparam int KeyBits    = 32;
   localparam int ValueBits  = 32;
   localparam int IdxBits    = $clog2(TableDepth);
   localparam int CntBits    = $clog2(TableDepth + 1);

   typedef logic [IdxBits-1:0] idx_type;
   typedef logic [CntBits-1:0] cnt_type;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_PUT    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_ENUM   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;
endpackage
`default_nettype wire

// File: rtl/core/sorted_key_value_table.sv
`default_nettype none
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_command, req_key_in, req_value_in
// rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_key_out, rsp_value_out,
//         |           | rsp_changed, rsp_entry_count, rsp_last
// One word at a time. After accept, each binary search step reads and then compares
// (up to 7 steps on a full table); then the found slot is read and the result goes
// to the output register. An insert or delete that changes the table moves the tail
// one entry at a time (read, write; up to 63 entries), and an insert then places the new
// pair. Enumerate reads one word, registers it and reads the next only once
// it is taken. Reset clears state, pair count and rsp_valid; the stores need none.
// req_stall is high from acceptance until the last result word has left.
module sorted_key_value_table (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_command,
   input  wire logic [31:0]                  req_key_in,
   input  wire logic [31:0]                  req_value_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [31:0]                       rsp_key_out,
   output logic [31:0]                       rsp_value_out,
   output logic                              rsp_changed,
   output logic [6:0]                        rsp_entry_count,
   output logic                              rsp_last
);
   import skvt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCHW, S_DECIDE, S_RESOLVE, S_SHIFT_RD, S_SHIFT_WR,
      S_ENUM_RD, S_ENUM_WR, S_OUT
   } state_type;

   // separate key and value stores, one port each used as read or write
   logic [KeyBits-1:0]   key_mem [TableDepth];
   logic [ValueBits-1:0] val_mem [TableDepth];

   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [KeyBits-1:0]   key_ff;
   logic [ValueBits-1:0] val_ff;
   cnt_type            count_ff;
   cnt_type            lo_ff, hi_ff, pos_ff, ptr_ff;
   logic [KeyBits-1:0]   rd_key_ff;
   logic [ValueBits-1:0] rd_val_ff;
   logic               rd_en, wr_en;
   idx_type            rd_addr, wr_addr;
   logic [KeyBits-1:0]   wr_key;
   logic [ValueBits-1:0] wr_val;
   cnt_type            mid;
   logic               hit_w;

   assign mid = cnt_type'((CntBits+1)'(lo_ff) + (CntBits+1)'(hi_ff) >> 1);
   assign hit_w = (pos_ff < count_ff) && (rd_key_ff == key_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
      end
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
   end

   // memory port control, from state
   always_comb begin
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      rd_addr = idx_type'(mid);
      wr_addr = idx_type'(ptr_ff);
      wr_key  = rd_key_ff;
      wr_val  = rd_val_ff;
      unique case (state_ff)
         S_SRCH: rd_en = 1'b1;
         S_DECIDE: begin
            rd_addr = idx_type'(pos_ff);
            rd_en   = (pos_ff < count_ff);
         end
         S_RESOLVE: begin
            // replace the value of a present key in place
            if (cmd_ff == CMD_PUT && hit_w) begin
               wr_en   = 1'b1;
               wr_addr = idx_type'(pos_ff);
               wr_key  = key_ff;
               wr_val  = val_ff;
            end
         end
         S_SHIFT_RD: begin
            if (cmd_ff == CMD_PUT) begin
               if (ptr_ff == pos_ff) begin
                  // gap reached: place the new pair
                  wr_en  = 1'b1;
                  wr_key = key_ff;
                  wr_val = val_ff;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_type'(ptr_ff - 1'b1);
               end
            end else if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_type'(ptr_ff + 1'b1);
            end
         end
         S_SHIFT_WR: wr_en = 1'b1;
         S_ENUM_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_type'(ptr_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               cmd_ff <= cmd_type'(req_command);
               key_ff <= req_key_in;
               val_ff <= req_value_in;
               lo_ff  <= '0;
               hi_ff  <= count_ff;
               pos_ff <= '0;
               ptr_ff <= '0;
               rsp_status <= ST_OK;
               rsp_key_out <= req_key_in;
               rsp_value_out <= '0;
               rsp_changed <= 1'b0;
               rsp_entry_count <= 7'(count_ff);
               rsp_last <= 1'b1;
               if (cmd_type'(req_command) == CMD_ENUM) begin
                  if (count_ff == '0) begin
                     rsp_status <= ST_NOTFOUND;
                     rsp_key_out <= '0;
                     rsp_valid <= 1'b1;
                     state_ff <= S_OUT;
                  end else state_ff <= S_ENUM_RD;
               end else if (count_ff == '0) begin
                  state_ff <= S_DECIDE;
               end else state_ff <= S_SRCH;
            end
            S_SRCH: state_ff <= S_SRCHW;
            S_SRCHW: begin
               if (rd_key_ff < key_ff) begin
                  if (mid + 1'b1 >= hi_ff) begin
                     pos_ff <= mid + 1'b1; state_ff <= S_DECIDE;
                  end else begin
                     lo_ff <= mid + 1'b1; state_ff <= S_SRCH;
                  end
               end else begin
                  if (mid <= lo_ff) begin
                     pos_ff <= mid; state_ff <= S_DECIDE;
                  end else begin
                     hi_ff <= mid; state_ff <= S_SRCH;
                  end
               end
            end
            S_DECIDE: state_ff <= S_RESOLVE;  // wait for entry at pos
            S_RESOLVE: begin
               unique case (cmd_ff)
                  CMD_LOOKUP: begin
                     if (hit_w) rsp_value_out <= rd_val_ff;
                     else rsp_status <= ST_NOTFOUND;
                     rsp_valid <= 1'b1; state_ff <= S_OUT;
                  end
                  CMD_PUT: begin
                     if (hit_w) begin
                        rsp_changed <= (rd_val_ff != val_ff);
                        rsp_valid <= 1'b1; state_ff <= S_OUT;
                     end else if (count_ff >= cnt_type'(TableDepth)) begin
                        rsp_status <= ST_FULL;
                        rsp_valid <= 1'b1; state_ff <= S_OUT;
                     end else begin
                        // open a gap at pos, moving the tail up from the top
                        rsp_changed <= 1'b1;
                        ptr_ff <= count_ff;
                        count_ff <= count_ff + 1'b1;
                        rsp_entry_count <= 7'(count_ff + 1'b1);
                        state_ff <= S_SHIFT_RD;
                     end
                  end
                  default: begin
                     if (hit_w) begin
                        // close the gap at pos, moving the tail down
                        rsp_value_out <= rd_val_ff;
                        rsp_changed <= 1'b1;
                        ptr_ff <= pos_ff;
                        count_ff <= count_ff - 1'b1;
                        rsp_entry_count <= 7'(count_ff - 1'b1);
                        state_ff <= S_SHIFT_RD;
                     end else begin
                        rsp_status <= ST_NOTFOUND;
                        rsp_valid <= 1'b1; state_ff <= S_OUT;
                     end
                  end
               endcase
            end
            S_SHIFT_RD: begin
               if (cmd_ff == CMD_PUT) begin
                  if (ptr_ff == pos_ff) begin
                     rsp_valid <= 1'b1; state_ff <= S_OUT;
                  end else state_ff <= S_SHIFT_WR;
               end else if (ptr_ff < count_ff) begin
                  state_ff <= S_SHIFT_WR;
               end else begin
                  rsp_valid <= 1'b1; state_ff <= S_OUT;
               end
            end
            S_SHIFT_WR: begin
               // copy landed and written at ptr: step the pointer
               if (cmd_ff == CMD_PUT) ptr_ff <= ptr_ff - 1'b1;
               else ptr_ff <= ptr_ff + 1'b1;
               state_ff <= S_SHIFT_RD;
            end
            S_ENUM_RD: state_ff <= S_ENUM_WR;
            S_ENUM_WR: begin
               rsp_key_out <= rd_key_ff;
               rsp_value_out <= rd_val_ff;
               rsp_last <= (ptr_ff + 1'b1 == count_ff);
               rsp_valid <= 1'b1;
               ptr_ff <= ptr_ff + 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  if (cmd_ff == CMD_ENUM && !rsp_last) state_ff <= S_ENUM_RD;
                  else state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(TableDepth)) else $error("count beyond depth");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("took word while result pending");
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RESOLVE) |=> $stable(count_ff))
      else $error("count moved outside resolve");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_key_out)
                                    && $stable(rsp_value_out)))
      else $error("stalled result changed");
endmodule
`default_nettype wire
